@@ design/mvm_pkg.sv @@
package mvm_pkg;

    localparam int NUM_ROWS = 16;
    localparam int NUM_COLS = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int VAL_W    = 16;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int SUM_W    = 36;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 5;

    // A run waits this long after the last column enters the chain, so that
    // the column has passed every cell and reached its accumulator.
    localparam int DRAIN_CYCLES = NUM_ROWS + 2;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

    typedef enum logic [1:0] {
        ACT_WRITE_WEIGHT = 2'd0,
        ACT_WRITE_VECTOR = 2'd1,
        ACT_RUN          = 2'd2,
        ACT_NONE         = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_ROWS = 1'b0,
        REG_ACTIVE_COLS = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN,
        S_UNLOAD
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             clear;
        logic             shift;
        logic             wr_en;
        logic [IDX_W-1:0] wr_row;
        logic [IDX_W-1:0] wr_col;
        logic [VAL_W-1:0] wr_data;
    } t_mvm_ctl;

    // One vector element travelling down the chain of cells.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] vec;
    } t_mvm_tok;

endpackage

@@ design/mvm_if.sv @@
interface mvm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  row_sel;
    logic [3:0]  col_sel;
    logic signed [15:0] value;

    modport source(output valid, action, row_sel, col_sel, value, input ready);
    modport sink(input valid, action, row_sel, col_sel, value, output ready);
endinterface

interface mvm_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  row_index;
    logic signed [35:0] row_sum;
    logic        last;

    modport source(output valid, row_index, row_sum, last, input ready);
    modport sink(input valid, row_index, row_sum, last, output ready);
endinterface

interface mvm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [4:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ design/mvm_cell.sv @@
module mvm_cell
    import mvm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [IDX_W-1:0]        i_row_id,
    input  t_mvm_ctl                i_ctl,
    input  t_mvm_tok                i_tok,
    output t_mvm_tok                o_tok,
    input  logic signed [SUM_W-1:0] i_next_sum,
    output logic signed [SUM_W-1:0] o_sum
);

    logic signed [VAL_W-1:0]  r_weight [NUM_COLS];
    t_mvm_tok                 r_tok;
    logic                     r_pvalid;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [SUM_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_row == i_row_id) begin
            r_weight[i_ctl.wr_col] <= i_ctl.wr_data;
        end
    end

    always_comb begin
        n_prod = $signed(r_weight[i_tok.col]) * $signed(i_tok.vec);
        n_acc  = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.shift) begin
            n_acc = i_next_sum;
        end else if (r_pvalid) begin
            n_acc = r_acc + {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_pvalid    <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_pvalid    <= i_tok.valid;
        end
        r_tok.col <= i_tok.col;
        r_tok.vec <= i_tok.vec;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
    end

    assign o_tok = r_tok;
    assign o_sum = r_acc;

endmodule

@@ design/mvm_ctrl.sv @@
module mvm_ctrl
    import mvm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    mvm_in_if.sink                  i_in,
    mvm_out_if.source               o_out,
    mvm_cfg_if.sink                 i_cfg,
    output t_mvm_ctl                o_ctl,
    output t_mvm_tok                o_tok,
    input  logic signed [SUM_W-1:0] i_head_sum
);

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_cfg_rows, r_cfg_cols;
    logic [CNT_W-1:0]        r_rows, n_rows;
    logic [CNT_W-1:0]        r_cols, n_cols;
    logic [CNT_W-1:0]        r_col, n_col;
    logic [CNT_W-1:0]        r_row, n_row;
    logic [DRAIN_W-1:0]      r_wait, n_wait;
    logic signed [VAL_W-1:0] r_vector [NUM_COLS];

    logic                    r_o_valid, n_o_valid;
    logic [IDX_W-1:0]        r_o_row, n_o_row;
    logic signed [SUM_W-1:0] r_o_sum, n_o_sum;
    logic                    r_o_last, n_o_last;

    logic                    w_in_acc;
    logic                    w_vec_wr;
    logic [CNT_W-1:0]        w_rows_clamped, w_cols_clamped;
    logic                    w_out_free;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_o_valid || o_out.ready;

    assign w_rows_clamped = (r_cfg_rows > CNT_W'(NUM_ROWS)) ? CNT_W'(NUM_ROWS) : r_cfg_rows;
    assign w_cols_clamped = (r_cfg_cols > CNT_W'(NUM_COLS)) ? CNT_W'(NUM_COLS) : r_cfg_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= CFG_W'(NUM_ROWS);
            r_cfg_cols <= CFG_W'(NUM_COLS);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_ACTIVE_ROWS: r_cfg_rows <= i_cfg.data;
                REG_ACTIVE_COLS: r_cfg_cols <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_vec_wr = w_in_acc && t_action'(i_in.action) == ACT_WRITE_VECTOR;

    always_ff @(posedge i_clk) begin
        if (w_vec_wr) begin
            r_vector[i_in.col_sel] <= i_in.value;
        end
    end

    // The column token enters cell 0; each cell registers it for the next.
    assign o_tok.valid = (r_state == S_FEED);
    assign o_tok.col   = r_col[IDX_W-1:0];
    assign o_tok.vec   = r_vector[r_col[IDX_W-1:0]];

    always_comb begin
        n_state   = r_state;
        n_rows    = r_rows;
        n_cols    = r_cols;
        n_col     = r_col;
        n_row     = r_row;
        n_wait    = r_wait;
        n_o_valid = r_o_valid;
        n_o_row   = r_o_row;
        n_o_sum   = r_o_sum;
        n_o_last  = r_o_last;

        o_ctl.clear   = 1'b0;
        o_ctl.shift   = 1'b0;
        o_ctl.wr_en   = w_in_acc && t_action'(i_in.action) == ACT_WRITE_WEIGHT;
        o_ctl.wr_row  = i_in.row_sel;
        o_ctl.wr_col  = i_in.col_sel;
        o_ctl.wr_data = i_in.value;

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && t_action'(i_in.action) == ACT_RUN) begin
                    o_ctl.clear = 1'b1;
                    n_rows      = w_rows_clamped;
                    n_cols      = w_cols_clamped;
                    n_col       = '0;
                    n_wait      = '0;
                    n_state     = (w_cols_clamped == '0) ? S_DRAIN : S_FEED;
                end
            end
            S_FEED: begin
                n_col = r_col + 1'b1;
                if (r_col + 1'b1 == r_cols) begin
                    n_wait  = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_wait = r_wait + 1'b1;
                if (r_wait == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    n_row   = '0;
                    n_state = (r_rows == '0) ? S_IDLE : S_UNLOAD;
                end
            end
            S_UNLOAD: begin
                // Row sums leave through cell 0 while the chain shifts toward it.
                if (w_out_free) begin
                    o_ctl.shift = 1'b1;
                    n_o_valid   = 1'b1;
                    n_o_row     = r_row[IDX_W-1:0];
                    n_o_sum     = i_head_sum;
                    n_o_last    = (r_row + 1'b1 == r_rows);
                    n_row       = r_row + 1'b1;
                    if (r_row + 1'b1 == r_rows) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_rows    <= '0;
            r_cols    <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_wait    <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_rows    <= n_rows;
            r_cols    <= n_cols;
            r_col     <= n_col;
            r_row     <= n_row;
            r_wait    <= n_wait;
        end
        r_o_row  <= n_o_row;
        r_o_sum  <= n_o_sum;
        r_o_last <= n_o_last;
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.row_index = r_o_row;
    assign o_out.row_sum   = r_o_sum;
    assign o_out.last      = r_o_last;

    a_feed_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FEED |-> r_col < r_cols)
        else $error("column counter ran past the active column count");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.shift && r_row + 1'b1 == r_rows |=> r_state == S_IDLE && r_o_valid && r_o_last)
        else $error("final row result did not end the run");

    a_clear_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.clear |=> r_state == S_FEED || r_state == S_DRAIN)
        else $error("accumulator clear without a run starting");

    a_shift_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.shift |-> r_state == S_UNLOAD && w_out_free && r_row < r_rows)
        else $error("chain shifted with no free output slot");

endmodule

@@ design/matrix_vector_multiply_top.sv @@
// Channel  Dir  Payload                              Accepted when
// i_in     in   action, row_sel, col_sel, value      valid && ready
// o_out    out  row_index, row_sum, last             valid && ready
// i_cfg    in   index (0 rows, 1 cols), data         valid && ready (ready always high)
//
// Weight and vector writes leave the block idle, so writes can be taken back to back.
// A run streams the vector through the chain of 16 row cells and drains it, then
// shifts out one row sum per cycle for each active row, from cell 0.
// Output stalls hold the chain; no item is taken until the last row has been issued.
// Reset is synchronous and active low; weights and vector elements are not cleared.
module matrix_vector_multiply_top
    import mvm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvm_in_if.sink     i_in,
    mvm_out_if.source  o_out,
    mvm_cfg_if.sink    i_cfg
);

    t_mvm_ctl                w_ctl;
    t_mvm_tok                w_tok [NUM_ROWS+1];
    logic signed [SUM_W-1:0] w_sum [NUM_ROWS+1];

    assign w_sum[NUM_ROWS] = '0;

    mvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg      (i_cfg),
        .o_ctl      (w_ctl),
        .o_tok      (w_tok[0]),
        .i_head_sum (w_sum[0])
    );

    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_cell
        mvm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_row_id   (IDX_W'(g)),
            .i_ctl      (w_ctl),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1]),
            .i_next_sum (w_sum[g+1]),
            .o_sum      (w_sum[g])
        );
    end

endmodule
